@@ src/slkc_pkg.sv @@
package slkc_pkg;

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_ERASE  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

@@ src/slkc_req_if.sv @@
interface slkc_req_if;
	logic                        valid;
	logic                        ready;
	logic [slkc_pkg::FUNC_W-1:0] func;
	logic [slkc_pkg::KEY_W-1:0]  handle;
	logic [slkc_pkg::DATA_W-1:0] payload;

	modport source (output valid, output func, output handle, output payload, input ready);
	modport sink (input valid, input func, input handle, input payload, output ready);
endinterface

@@ src/slkc_rsp_if.sv @@
interface slkc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [slkc_pkg::DATA_W-1:0] data;
	logic                        evicted;
	logic [slkc_pkg::KEY_W-1:0]  evicted_handle;

	modport source (output valid, output hit, output data, output evicted,
		output evicted_handle, input ready);
	modport sink (input valid, input hit, input data, input evicted,
		input evicted_handle, output ready);
endinterface

@@ src/slkc_ctrl.sv @@
module slkc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  slkc_pkg::sts_t sts,
	output slkc_pkg::cmd_t cmd
);

	slkc_pkg::state_t state_q;
	slkc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slkc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			slkc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = slkc_pkg::ST_SCAN;
				end
			end
			slkc_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = slkc_pkg::ST_DRAIN;
				end
			end
			// last read beat is compared here
			slkc_pkg::ST_DRAIN: begin
				state_d = slkc_pkg::ST_COMMIT;
			end
			slkc_pkg::ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = slkc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slkc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/slkc_dp.sv @@
module slkc_dp #(
	parameter int SHARD_BITS     = 2,
	parameter int WAYS_PER_SHARD = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [slkc_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic [slkc_pkg::FUNC_W-1:0] req_func,
	input  logic [slkc_pkg::KEY_W-1:0]  req_handle,
	input  logic [slkc_pkg::DATA_W-1:0] req_payload,
	input  slkc_pkg::cmd_t              cmd,
	output slkc_pkg::sts_t              sts,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic                        rsp_hit,
	output logic [slkc_pkg::DATA_W-1:0] rsp_data,
	output logic                        rsp_evicted,
	output logic [slkc_pkg::KEY_W-1:0]  rsp_evicted_handle
);

	localparam int SHARD_COUNT = 1 << SHARD_BITS;
	localparam int SHARD_W     = (SHARD_BITS > 0) ? SHARD_BITS : 1;
	localparam int TOTAL       = SHARD_COUNT * WAYS_PER_SHARD;
	localparam int WAY_W       = (WAYS_PER_SHARD > 1) ? $clog2(WAYS_PER_SHARD) : 1;
	localparam int RANK_W      = WAY_W;
	localparam int ADDR_W      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int FILL_W      = $clog2(WAYS_PER_SHARD + 1);
	localparam int SUM_W       = slkc_pkg::CAP_W + 1;
	localparam int KEY_W       = slkc_pkg::KEY_W;
	localparam int DATA_W      = slkc_pkg::DATA_W;

	// configuration and per-shard limit
	logic [slkc_pkg::CAP_W-1:0] cap_q;
	logic [SUM_W-1:0]           cap_sum;
	logic [SUM_W-1:0]           cap_div;
	logic [FILL_W-1:0]          lim_calc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= slkc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign cap_sum = SUM_W'(cap_q) + SUM_W'(SHARD_COUNT - 1);
	assign cap_div = cap_sum >> SHARD_BITS;

	always_comb begin
		if (cap_div == '0) begin
			lim_calc = FILL_W'(1);
		end else if (cap_div > SUM_W'(WAYS_PER_SHARD)) begin
			lim_calc = FILL_W'(WAYS_PER_SHARD);
		end else begin
			lim_calc = FILL_W'(cap_div);
		end
	end

	// operation registers
	logic [slkc_pkg::FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]            handle_q;
	logic [DATA_W-1:0]           payload_q;
	logic [SHARD_W-1:0]          shard_q;
	logic [FILL_W-1:0]           fill_cur_q;
	logic [FILL_W-1:0]           lim_q;
	logic [FILL_W-1:0]           shard_fill_q [SHARD_COUNT];
	logic [FILL_W-1:0]           fill_nxt;
	logic [SHARD_W-1:0]          shard_in;

	assign shard_in = SHARD_W'(req_handle & KEY_W'(SHARD_COUNT - 1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q     <= req_func;
			handle_q   <= req_handle;
			payload_q  <= req_payload;
			shard_q    <= shard_in;
			fill_cur_q <= shard_fill_q[shard_in];
			lim_q      <= lim_calc;
		end
	end

	// scan pointer and memory read stage
	logic [WAY_W-1:0]  ptr_q;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	logic [KEY_W-1:0]  key_mem [TOTAL];
	logic [DATA_W-1:0] val_mem [TOTAL];
	logic              valid_q [TOTAL];
	logic [RANK_W-1:0] rank_q  [TOTAL];

	logic              samp_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [DATA_W-1:0] val_s1;
	logic [WAY_W-1:0]  way_s1;
	logic              ent_s1;
	logic [RANK_W-1:0] rank_s1;

	assign base    = ADDR_W'(shard_q) * ADDR_W'(WAYS_PER_SHARD);
	assign rd_addr = base + ADDR_W'(ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			samp_s1 <= 1'b0;
		end else begin
			samp_s1 <= cmd.issue;
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (cmd.issue) begin
				ptr_q <= ptr_q + WAY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			key_s1  <= key_mem[rd_addr];
			val_s1  <= val_mem[rd_addr];
			way_s1  <= ptr_q;
			ent_s1  <= valid_q[rd_addr];
			rank_s1 <= rank_q[rd_addr];
		end
	end

	assign sts.scan_last = (ptr_q == WAY_W'(WAYS_PER_SHARD - 1));

	// scan trackers
	logic              hit_found_q;
	logic [WAY_W-1:0]  hit_way_q;
	logic [RANK_W-1:0] hit_rank_q;
	logic [DATA_W-1:0] hit_val_q;
	logic              slot_found_q;
	logic [WAY_W-1:0]  slot_way_q;
	logic [KEY_W-1:0]  old1_key_q;
	logic [KEY_W-1:0]  old2_key_q;

	logic [FILL_W-1:0] rank_ext;
	logic              key_match;
	logic              ev_miss;
	logic              slot_ok;

	assign rank_ext  = FILL_W'(rank_s1);
	assign key_match = samp_s1 && ent_s1 && (key_s1 == handle_q);
	// a new key into a shard at its limit pushes out everything from rank lim-1 up
	assign ev_miss   = (fill_cur_q >= lim_q);
	assign slot_ok   = samp_s1 && (!ent_s1 || (ev_miss && rank_ext >= lim_q - FILL_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			slot_found_q <= 1'b0;
		end else if (cmd.start) begin
			hit_found_q  <= 1'b0;
			slot_found_q <= 1'b0;
		end else begin
			if (key_match) begin
				hit_found_q <= 1'b1;
			end
			if (slot_ok) begin
				slot_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_match && !hit_found_q) begin
			hit_way_q  <= way_s1;
			hit_rank_q <= rank_s1;
			hit_val_q  <= val_s1;
		end
		if (slot_ok && !slot_found_q) begin
			slot_way_q <= way_s1;
		end
		// keys of the two least recent entries, for the eviction report
		if (samp_s1 && ent_s1 && rank_ext == fill_cur_q - FILL_W'(1)) begin
			old1_key_q <= key_s1;
		end
		if (samp_s1 && ent_s1 && rank_ext == fill_cur_q - FILL_W'(2)) begin
			old2_key_q <= key_s1;
		end
	end

	// per-entry valid and rank update at commit
	for (genvar e = 0; e < TOTAL; e++) begin : g_ent
		localparam int E_SHARD = e / WAYS_PER_SHARD;
		localparam int E_WAY   = e % WAYS_PER_SHARD;

		logic              sel;
		logic              is_hit_way;
		logic              is_slot;
		logic              nxt_valid;
		logic [RANK_W-1:0] nxt_rank;

		assign sel        = (SHARD_W'(E_SHARD) == shard_q);
		assign is_hit_way = hit_found_q && (WAY_W'(E_WAY) == hit_way_q);
		assign is_slot    = slot_found_q && (WAY_W'(E_WAY) == slot_way_q);

		always_comb begin
			nxt_valid = valid_q[e];
			nxt_rank  = rank_q[e];
			case (func_q)
				slkc_pkg::FUNC_LOOKUP: begin
					if (is_hit_way) begin
						nxt_rank = '0;
					end else if (hit_found_q && valid_q[e] && rank_q[e] < hit_rank_q) begin
						nxt_rank = rank_q[e] + RANK_W'(1);
					end
				end
				slkc_pkg::FUNC_ERASE: begin
					if (is_hit_way) begin
						nxt_valid = 1'b0;
					end else if (hit_found_q && valid_q[e] && rank_q[e] > hit_rank_q) begin
						nxt_rank = rank_q[e] - RANK_W'(1);
					end
				end
				slkc_pkg::FUNC_INSERT: begin
					if (hit_found_q) begin
						if (is_hit_way) begin
							nxt_rank = '0;
						end else if (valid_q[e] && rank_q[e] < hit_rank_q) begin
							nxt_rank = rank_q[e] + RANK_W'(1);
						end
						// shrink to the limit after the refresh
						if (valid_q[e] && FILL_W'(nxt_rank) >= lim_q) begin
							nxt_valid = 1'b0;
						end
					end else begin
						if (is_slot) begin
							nxt_valid = 1'b1;
							nxt_rank  = '0;
						end else if (valid_q[e] && ev_miss &&
							FILL_W'(rank_q[e]) >= lim_q - FILL_W'(1)) begin
							nxt_valid = 1'b0;
						end else if (valid_q[e]) begin
							nxt_rank = rank_q[e] + RANK_W'(1);
						end
					end
				end
				default: begin
					nxt_valid = valid_q[e];
				end
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[e] <= 1'b0;
				rank_q[e]  <= '0;
			end else if (cmd.commit && sel) begin
				valid_q[e] <= nxt_valid;
				rank_q[e]  <= nxt_rank;
			end
		end
	end

	// shard fill count
	always_comb begin
		fill_nxt = fill_cur_q;
		case (func_q)
			slkc_pkg::FUNC_ERASE: begin
				if (hit_found_q) begin
					fill_nxt = fill_cur_q - FILL_W'(1);
				end
			end
			slkc_pkg::FUNC_INSERT: begin
				if (hit_found_q) begin
					fill_nxt = (fill_cur_q > lim_q) ? lim_q : fill_cur_q;
				end else begin
					fill_nxt = (ev_miss ? lim_q - FILL_W'(1) : fill_cur_q) + FILL_W'(1);
				end
			end
			default: begin
				fill_nxt = fill_cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SHARD_COUNT; s++) begin
				shard_fill_q[s] <= '0;
			end
		end else if (cmd.commit) begin
			shard_fill_q[shard_q] <= fill_nxt;
		end
	end

	// key and payload memories
	logic is_ins;
	logic key_we;
	logic val_we;

	assign is_ins  = (func_q == slkc_pkg::FUNC_INSERT);
	assign key_we  = cmd.commit && is_ins && !hit_found_q;
	assign val_we  = cmd.commit && is_ins;
	assign wr_addr = base + ADDR_W'(hit_found_q ? hit_way_q : slot_way_q);

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= handle_q;
		end
		if (val_we) begin
			val_mem[wr_addr] <= payload_q;
		end
	end

	// result
	logic              res_hit;
	logic [DATA_W-1:0] res_data;
	logic              res_ev;
	logic [KEY_W-1:0]  res_ev_key;
	logic              known_func;
	logic              hit_was_oldest;

	assign known_func = (func_q == slkc_pkg::FUNC_LOOKUP) ||
		(func_q == slkc_pkg::FUNC_INSERT) || (func_q == slkc_pkg::FUNC_ERASE);
	assign res_hit  = known_func && hit_found_q;
	assign res_data = ((func_q == slkc_pkg::FUNC_LOOKUP) && hit_found_q) ? hit_val_q : '0;
	assign res_ev   = is_ins && (hit_found_q ? (fill_cur_q > lim_q) : ev_miss);
	// refreshing the oldest entry leaves the second oldest as the first victim
	assign hit_was_oldest = hit_found_q && (FILL_W'(hit_rank_q) == fill_cur_q - FILL_W'(1));

	always_comb begin
		if (!res_ev) begin
			res_ev_key = '0;
		end else if (hit_was_oldest) begin
			res_ev_key = old2_key_q;
		end else begin
			res_ev_key = old1_key_q;
		end
	end

	logic              out_valid_q;
	logic              out_hit_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_ev_q;
	logic [KEY_W-1:0]  out_ev_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q    <= res_hit;
			out_data_q   <= res_data;
			out_ev_q     <= res_ev;
			out_ev_key_q <= res_ev_key;
		end
	end

	assign rsp_valid          = out_valid_q;
	assign rsp_hit            = out_hit_q;
	assign rsp_data           = out_data_q;
	assign rsp_evicted        = out_ev_q;
	assign rsp_evicted_handle = out_ev_key_q;
	assign sts.out_free       = !out_valid_q || rsp_ready;

endmodule

@@ src/sharded_lru_key_cache.sv @@
// Sharded LRU key cache.
// req (sink): one beat carries func (lookup, insert, erase), handle and payload.
// The low SHARD_BITS bits of handle pick a shard of WAYS_PER_SHARD ways.
// rsp (source): one beat per request with hit, data, evicted, evicted_handle.
// cfg_we/cfg_wdata write total_capacity; the per-shard limit is
// ceil(total_capacity / shard count), clamped to 1..WAYS_PER_SHARD.
// Write it only while no request is in flight.
// Timing: each request scans its shard's key memory one way per cycle.
// The response becomes valid after the scan, drain and commit states, and a
// new request is taken only after the previous one has committed.
// The response register holds a finished result while the next request is
// scanned; if rsp stays stalled, the second request waits before its commit
// and req.ready stays low until the response slot frees.
// Reset clears all valid bits, recency ranks and fill counts, and sets
// total_capacity to 64. Keys and payloads are not cleared.
module sharded_lru_key_cache #(
	parameter int SHARD_BITS     = 2,
	parameter int WAYS_PER_SHARD = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	slkc_req_if.sink                   req,
	slkc_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [slkc_pkg::CAP_W-1:0] cfg_wdata
);

	slkc_pkg::cmd_t cmd;
	slkc_pkg::sts_t sts;

	slkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slkc_dp #(
		.SHARD_BITS     (SHARD_BITS),
		.WAYS_PER_SHARD (WAYS_PER_SHARD)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.req_func           (req.func),
		.req_handle         (req.handle),
		.req_payload        (req.payload),
		.cmd                (cmd),
		.sts                (sts),
		.rsp_ready          (rsp.ready),
		.rsp_valid          (rsp.valid),
		.rsp_hit            (rsp.hit),
		.rsp_data           (rsp.data),
		.rsp_evicted        (rsp.evicted),
		.rsp_evicted_handle (rsp.evicted_handle)
	);

endmodule

@@ src/slkc_chk.sv @@
module slkc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_hit,
	input logic [slkc_pkg::DATA_W-1:0] rsp_data,
	input logic                        rsp_evicted,
	input logic [slkc_pkg::KEY_W-1:0]  rsp_evicted_handle
);

	logic       req_beat;
	logic       rsp_beat;
	logic [1:0] pend_q;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_beat && !rsp_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_beat && !req_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response with no request outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req_ready)
		else $error("request taken while previous one is scanning");

	a_miss_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_data == '0)
		else $error("data nonzero on miss");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted |-> rsp_evicted_handle == '0)
		else $error("evicted_handle nonzero without eviction");

endmodule

bind sharded_lru_key_cache slkc_chk u_slkc_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_hit            (rsp.hit),
	.rsp_data           (rsp.data),
	.rsp_evicted        (rsp.evicted),
	.rsp_evicted_handle (rsp.evicted_handle)
);
